### src/tcd_pkg.sv
// Shared types and constants for the tilt climb detector.
`default_nettype none
package tcd_pkg;

    localparam int PITCH_W   = 16;
    localparam int TIME_W    = 32;
    localparam int BIAS_W    = 24;
    localparam int ALPHA_W   = 17;
    localparam int TMO_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIMEOUT   = 3'd0,
        REG_BIAS_ALPHA     = 3'd1,
        REG_UP_ENTER       = 3'd2,
        REG_UP_RELEASE     = 3'd3,
        REG_DOWN_ENTER     = 3'd4,
        REG_DOWN_RELEASE   = 3'd5
    } cfg_reg_t;

    localparam logic [TMO_W-1:0]   HOLD_TIMEOUT_RST = 16'd500;
    localparam logic [ALPHA_W-1:0] BIAS_ALPHA_RST   = 17'd655;

    typedef struct packed {
        logic [TMO_W-1:0]          hold_timeout_ms;
        logic [ALPHA_W-1:0]        bias_alpha;
        logic signed [PITCH_W-1:0] up_enter_level;
        logic signed [PITCH_W-1:0] up_release_level;
        logic signed [PITCH_W-1:0] down_enter_level;
        logic signed [PITCH_W-1:0] down_release_level;
    } cfg_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [PITCH_W-1:0] pitch_sample;
        logic [TIME_W-1:0]         now_ms;
    } item_t;

    typedef struct packed {
        logic                     climbing;
        logic                     up_active;
        logic                     down_active;
        logic signed [BIAS_W-1:0] bias_out;
    } result_t;

endpackage
`default_nettype wire

### src/tcd_core.sv
// Detector state and the per-item update: hysteresis flags, hold timer, bias average.
`default_nettype none
module tcd_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcd_pkg::cfg_t  cfg,
    input  wire logic           step,
    input  wire tcd_pkg::item_t item,
    output tcd_pkg::result_t    result
);

    logic                              up_flag_reg, up_flag_next;
    logic                              down_flag_reg, down_flag_next;
    logic [tcd_pkg::TIME_W-1:0]        up_entry_reg, up_entry_next;
    logic [tcd_pkg::TIME_W-1:0]        down_entry_reg, down_entry_next;
    logic signed [tcd_pkg::BIAS_W-1:0] bias_reg, bias_next;

    logic signed [tcd_pkg::BIAS_W-1:0] pitch_q20;
    logic signed [tcd_pkg::BIAS_W:0]   corr_up, corr_down, diff;
    logic signed [tcd_pkg::BIAS_W:0]   up_enter_q, up_rel_q, down_enter_q, down_rel_q;
    logic [tcd_pkg::TIME_W-1:0]        up_elapsed, down_elapsed;
    logic                              up_set, up_rel, down_set, down_rel;
    logic                              up_n, down_n;
    logic signed [tcd_pkg::BIAS_W-1:0] bias_mid, bias_post;
    logic [tcd_pkg::ALPHA_W-1:0]       alpha;
    logic signed [42:0]                prod;
    logic signed [43:0]                acc;
    logic signed [27:0]                avg;
    logic signed [tcd_pkg::BIAS_W-1:0] avg_sat;

    always_comb
    begin
        pitch_q20    = {item.pitch_sample, 8'd0};
        up_enter_q   = {cfg.up_enter_level[15], cfg.up_enter_level, 8'd0};
        up_rel_q     = {cfg.up_release_level[15], cfg.up_release_level, 8'd0};
        down_enter_q = {cfg.down_enter_level[15], cfg.down_enter_level, 8'd0};
        down_rel_q   = {cfg.down_release_level[15], cfg.down_release_level, 8'd0};
        up_elapsed   = item.now_ms - up_entry_reg;
        down_elapsed = item.now_ms - down_entry_reg;

        // up flag sees the stored bias
        corr_up = {pitch_q20[23], pitch_q20} - {bias_reg[23], bias_reg};
        up_set  = !up_flag_reg && (corr_up < up_enter_q);
        up_rel  = up_flag_reg && (corr_up >= up_rel_q)
                  && (up_elapsed > {16'd0, cfg.hold_timeout_ms});
        up_n     = up_set ? 1'b1 : (up_rel ? 1'b0 : up_flag_reg);
        bias_mid = up_rel ? '0 : bias_reg;

        // down flag sees the bias after a possible up release
        corr_down = {pitch_q20[23], pitch_q20} - {bias_mid[23], bias_mid};
        down_set  = !down_flag_reg && (corr_down > down_enter_q);
        down_rel  = down_flag_reg && (corr_down <= down_rel_q)
                    && (down_elapsed > {16'd0, cfg.hold_timeout_ms});
        down_n    = down_set ? 1'b1 : (down_rel ? 1'b0 : down_flag_reg);
        bias_post = down_rel ? '0 : bias_mid;

        // bias*(1-a) + p*a == bias + (p-bias)*a, one multiplier
        alpha = cfg.bias_alpha[16] ? 17'h10000 : cfg.bias_alpha;
        diff  = {pitch_q20[23], pitch_q20} - {bias_post[23], bias_post};
        prod  = 43'(diff) * 43'($signed({1'b0, alpha}));
        acc   = {prod[42], prod} + {{4{bias_post[23]}}, bias_post, 16'd0}
                + 44'sd32768;
        avg   = acc[43:16];
        if (avg[27:23] != {5{avg[23]}})
        begin
            avg_sat = avg[27] ? 24'sh800000 : 24'sh7fffff;
        end
        else
        begin
            avg_sat = avg[23:0];
        end

        up_flag_next    = up_flag_reg;
        down_flag_next  = down_flag_reg;
        up_entry_next   = up_entry_reg;
        down_entry_next = down_entry_reg;
        bias_next       = bias_reg;
        if (step)
        begin
            if (item.req_type)
            begin
                up_flag_next   = 1'b0;
                down_flag_next = 1'b0;
                bias_next      = '0;
            end
            else
            begin
                up_flag_next   = up_n;
                down_flag_next = down_n;
                if (up_set)
                begin
                    up_entry_next = item.now_ms;
                end
                if (down_set)
                begin
                    down_entry_next = item.now_ms;
                end
                bias_next = (!up_n && !down_n) ? avg_sat : bias_post;
            end
        end

        result.up_active   = up_flag_next;
        result.down_active = down_flag_next;
        result.climbing    = up_flag_next | down_flag_next;
        result.bias_out    = bias_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_flag_reg    <= 1'b0;
            down_flag_reg  <= 1'b0;
            up_entry_reg   <= '0;
            down_entry_reg <= '0;
            bias_reg       <= '0;
        end
        else
        begin
            up_flag_reg    <= up_flag_next;
            down_flag_reg  <= down_flag_next;
            up_entry_reg   <= up_entry_next;
            down_entry_reg <= down_entry_next;
            bias_reg       <= bias_next;
        end
    end

endmodule
`default_nettype wire

### src/tilt_climb_detector_top.sv
// Top level of the tilt climb detector: stream ports, config registers, item and result registers.
//
// Takes one item per clock while the output side keeps taking results and gives one result
// per item. An accepted item sits in an input register; when the output register is free or
// being read, the flag/bias update (compares, hold timer and one 25x18 multiply for the bias
// average) runs against the stored state and the result is registered in the output
// register, which drives m_axis_tvalid; a stalled output holds the item in the input register.
// A clear request (tuser = 1) drops both flags and the bias and still produces a result. Config writes
// are accepted every cycle and should only be made while no item is in flight.
`default_nettype none
module tilt_climb_detector_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [tcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // pitch_sample[15:0], now_ms[47:16]
    input  wire logic                               s_axis_tuser,  // req_type
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [tcd_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // climbing[0], up_active[1],
                                                                   // down_active[2], bias_out[26:3]
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tcd_pkg::CFG_DAT_W-1:0]      cfg_data
);

    tcd_pkg::cfg_t    cfg_reg;
    tcd_pkg::item_t   item_reg;
    logic             item_valid_reg;
    tcd_pkg::result_t result;
    tcd_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             step;

    assign step          = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || step;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.bias_out, out_reg.down_active,
                            out_reg.up_active, out_reg.climbing};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_timeout_ms    <= tcd_pkg::HOLD_TIMEOUT_RST;
            cfg_reg.bias_alpha         <= tcd_pkg::BIAS_ALPHA_RST;
            cfg_reg.up_enter_level     <= '0;
            cfg_reg.up_release_level   <= '0;
            cfg_reg.down_enter_level   <= '0;
            cfg_reg.down_release_level <= '0;
        end
        else if (cfg_valid)
        begin
            case (tcd_pkg::cfg_reg_t'(cfg_index))
                tcd_pkg::REG_HOLD_TIMEOUT: cfg_reg.hold_timeout_ms    <= cfg_data[15:0];
                tcd_pkg::REG_BIAS_ALPHA:   cfg_reg.bias_alpha         <= cfg_data;
                tcd_pkg::REG_UP_ENTER:     cfg_reg.up_enter_level     <= cfg_data[15:0];
                tcd_pkg::REG_UP_RELEASE:   cfg_reg.up_release_level   <= cfg_data[15:0];
                tcd_pkg::REG_DOWN_ENTER:   cfg_reg.down_enter_level   <= cfg_data[15:0];
                tcd_pkg::REG_DOWN_RELEASE: cfg_reg.down_release_level <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.req_type     <= s_axis_tuser;
            item_reg.pitch_sample <= s_axis_tdata[15:0];
            item_reg.now_ms       <= s_axis_tdata[47:16];
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    tcd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .step   (step),
        .item   (item_reg),
        .result (result)
    );

endmodule
`default_nettype wire

### src/tcd_checker.sv
// Port-level checks for the tilt climb detector, bound to the top level.
`default_nettype none
module tcd_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [tcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    a_climbing_is_or: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[1] | m_axis_tdata[2])))
        else $error("climbing does not match the flags");

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind tilt_climb_detector_top tcd_checker u_tcd_checker (.*);
`default_nettype wire

### tb/sv/tilt_climb_detector_top_tb.sv
// Self-checking stream testbench for the tilt climb detector top level.
module tilt_climb_detector_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int DIRECTED_N     = 20;
    localparam int SPLIT_ROW      = 9;
    localparam int RAND_PER_PHASE = 370;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int Q_ONE          = 65536;

    // indexes with no register behind them; writes must be dropped
    localparam logic [tcd_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [tcd_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        tcd_pkg::item_t   it;
        bit               typed;
        tcd_pkg::result_t want;
    } row_t;

    // first rows run on reset settings with typed results, the rest on the predictor
    localparam row_t WALK_ROWS [DIRECTED_N] = '{
        '{'{1'b0, 16'sd0,     32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0}},
        '{'{1'b0, 16'sh8000,  32'd100},        1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0}},
        '{'{1'b0, 16'sh7fff,  32'd200},        1'b1, '{1'b1, 1'b1, 1'b1, 24'sd0}},
        '{'{1'b0, 16'sd0,     32'd601},        1'b1, '{1'b1, 1'b0, 1'b1, 24'sd0}},
        '{'{1'b0, 16'sd0,     32'd701},        1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0}},
        '{'{1'b1, 16'sh7fff,  32'hffff_ffff},  1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0}},
        '{'{1'b0, 16'sh7fff,  32'hffff_ffff},  1'b1, '{1'b1, 1'b0, 1'b1, 24'sd0}},
        '{'{1'b0, 16'sh8000,  32'd500},        1'b1, '{1'b1, 1'b1, 1'b0, 24'sd0}},
        '{'{1'b1, 16'sd0,     32'd0},          1'b1, '{1'b0, 1'b0, 1'b0, 24'sd0}},
        '{'{1'b0, 16'sd2000,  32'd10},         1'b0, '0},
        '{'{1'b0, -16'sd8000, 32'd11},         1'b0, '0},
        '{'{1'b0, 16'sd4500,  32'd12},         1'b0, '0},
        '{'{1'b0, -16'sd3000, 32'd12},         1'b0, '0},
        '{'{1'b0, -16'sd3000, 32'd13},         1'b0, '0},
        '{'{1'b0, 16'sh7fff,  32'd14},         1'b0, '0},
        '{'{1'b1, 16'sd0,     32'd15},         1'b0, '0},
        '{'{1'b0, 16'sh8000,  32'd16},         1'b0, '0},
        '{'{1'b0, 16'sd0,     32'd16},         1'b0, '0},
        '{'{1'b0, 16'sd0,     32'd17},         1'b0, '0},
        '{'{1'b0, 16'sd1,     32'd18},         1'b0, '0}
    };

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [tcd_pkg::IN_TDATA_W-1:0]        s_axis_tdata;   // pitch_sample[15:0], now_ms[47:16]
    logic                                  s_axis_tuser;   // req_type
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [tcd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata;   // climbing[0], up_active[1],
                                                           // down_active[2], bias_out[26:3]
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [tcd_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [tcd_pkg::CFG_DAT_W-1:0]         cfg_data;

    // typed expectation travelling with the item on the bus
    logic                                  row_typed;
    tcd_pkg::result_t                      row_want;

    // predictor state and its copy of the registers
    tcd_pkg::cfg_t                         cfg_m;
    logic                                  up_on;
    logic                                  down_on;
    logic [tcd_pkg::TIME_W-1:0]            up_since;
    logic [tcd_pkg::TIME_W-1:0]            down_since;
    logic signed [tcd_pkg::BIAS_W-1:0]     bias_q20;

    tcd_pkg::result_t                      results_due[$];
    logic [tcd_pkg::TIME_W-1:0]            stamp_ms;
    int                      src_idle_pct  = 0;
    int                      sink_stall_pct = 0;
    int                      err_count     = 0;
    int                      n_items       = 0;
    int                      n_clears      = 0;
    int                      n_results     = 0;
    int                      n_cfg         = 0;
    int                      n_up_seen     = 0;
    int                      n_down_seen   = 0;
    int                      n_bias_seen   = 0;
    int                      idle_cycles   = 0;

    tilt_climb_detector_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Flag and bias update for one item; advances the predictor state.
    function automatic tcd_pkg::result_t climb_predict(input tcd_pkg::item_t it);
        longint           p20;
        longint           corr;
        longint           a;
        longint           sum;
        longint           r;
        tcd_pkg::result_t res;
        p20 = longint'(it.pitch_sample) * 256;
        if (it.req_type)
        begin
            up_on    = 1'b0;
            down_on  = 1'b0;
            bias_q20 = '0;
        end
        else
        begin
            corr = p20 - longint'(bias_q20);
            if (!up_on && corr < longint'(cfg_m.up_enter_level) * 256)
            begin
                up_on    = 1'b1;
                up_since = it.now_ms;
            end
            else if (up_on && corr >= longint'(cfg_m.up_release_level) * 256)
            begin
                if (32'(it.now_ms - up_since) > cfg_m.hold_timeout_ms)
                begin
                    up_on    = 1'b0;
                    bias_q20 = '0;
                end
            end
            // down side sees the bias as left by the up side
            corr = p20 - longint'(bias_q20);
            if (!down_on && corr > longint'(cfg_m.down_enter_level) * 256)
            begin
                down_on    = 1'b1;
                down_since = it.now_ms;
            end
            else if (down_on && corr <= longint'(cfg_m.down_release_level) * 256)
            begin
                if (32'(it.now_ms - down_since) > cfg_m.hold_timeout_ms)
                begin
                    down_on  = 1'b0;
                    bias_q20 = '0;
                end
            end
            if (!up_on && !down_on)
            begin
                a   = (cfg_m.bias_alpha > Q_ONE) ? Q_ONE : cfg_m.bias_alpha;
                sum = longint'(bias_q20) * (Q_ONE - a) + p20 * a;
                r   = (sum + 32768) >>> 16;   // round half up
                if (r > 64'sd8388607)
                    r = 64'sd8388607;
                if (r < -64'sd8388608)
                    r = -64'sd8388608;
                bias_q20 = r[tcd_pkg::BIAS_W-1:0];
            end
        end
        res.climbing    = up_on | down_on;
        res.up_active   = up_on;
        res.down_active = down_on;
        res.bias_out    = bias_q20;
        return res;
    endfunction

    // Random reading: mostly near a level relative to the bias, stamps stepping past the hold.
    function automatic tcd_pkg::item_t next_reading();
        tcd_pkg::item_t it;
        int             lvl;
        int             off;
        int             center;
        int             bs;
        it.req_type = ($urandom_range(99) < 4);
        if ($urandom_range(99) < 3)
            stamp_ms = $urandom();
        else
            stamp_ms = stamp_ms + $urandom_range(cfg_m.hold_timeout_ms / 2 + 2);
        it.now_ms = stamp_ms;
        if ($urandom_range(3) == 0)
            it.pitch_sample = 16'($urandom());
        else
        begin
            case ($urandom_range(3))
                0:       lvl = int'(cfg_m.up_enter_level);
                1:       lvl = int'(cfg_m.up_release_level);
                2:       lvl = int'(cfg_m.down_enter_level);
                default: lvl = int'(cfg_m.down_release_level);
            endcase
            bs     = int'(bias_q20) >>> 8;
            off    = $urandom_range(64);
            center = lvl + bs + off - 32;
            if (center > 32767)
                center = 32767;
            if (center < -32768)
                center = -32768;
            it.pitch_sample = center[tcd_pkg::PITCH_W-1:0];
        end
        return it;
    endfunction

    task automatic report_mismatch(input string fld, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_item(input tcd_pkg::item_t it, input bit typed,
                             input tcd_pkg::result_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.now_ms, it.pitch_sample};
        s_axis_tuser  <= it.req_type;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [tcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcd_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_settings(input int tmo, input int alpha, input int ue, input int ur,
                                 input int de, input int dr);
        cfg_write(tcd_pkg::REG_HOLD_TIMEOUT, tmo[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(tcd_pkg::REG_BIAS_ALPHA,   alpha[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(tcd_pkg::REG_UP_ENTER,     ue[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(tcd_pkg::REG_UP_RELEASE,   ur[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(tcd_pkg::REG_DOWN_ENTER,   de[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(tcd_pkg::REG_DOWN_RELEASE, dr[tcd_pkg::CFG_DAT_W-1:0]);
        cfg_write(REG_SPARE_6,               17'($urandom()));
        cfg_write(REG_SPARE_7,               17'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : scoreboard
        tcd_pkg::item_t   got_item;
        tcd_pkg::result_t want;
        tcd_pkg::result_t seen;
        tcd_pkg::result_t model_res;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_index)
                    tcd_pkg::REG_HOLD_TIMEOUT:
                        cfg_m.hold_timeout_ms    = cfg_data[tcd_pkg::TMO_W-1:0];
                    tcd_pkg::REG_BIAS_ALPHA:
                        cfg_m.bias_alpha         = cfg_data[tcd_pkg::ALPHA_W-1:0];
                    tcd_pkg::REG_UP_ENTER:
                        cfg_m.up_enter_level     = cfg_data[tcd_pkg::PITCH_W-1:0];
                    tcd_pkg::REG_UP_RELEASE:
                        cfg_m.up_release_level   = cfg_data[tcd_pkg::PITCH_W-1:0];
                    tcd_pkg::REG_DOWN_ENTER:
                        cfg_m.down_enter_level   = cfg_data[tcd_pkg::PITCH_W-1:0];
                    tcd_pkg::REG_DOWN_RELEASE:
                        cfg_m.down_release_level = cfg_data[tcd_pkg::PITCH_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                got_item.req_type     = s_axis_tuser;
                got_item.pitch_sample = s_axis_tdata[tcd_pkg::PITCH_W-1:0];
                got_item.now_ms       = s_axis_tdata[tcd_pkg::PITCH_W +: tcd_pkg::TIME_W];
                model_res = climb_predict(got_item);
                results_due.push_back(row_typed ? row_want : model_res);
                n_items++;
                if (got_item.req_type)
                    n_clears++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.climbing    = m_axis_tdata[0];
                seen.up_active   = m_axis_tdata[1];
                seen.down_active = m_axis_tdata[2];
                seen.bias_out    = m_axis_tdata[3 +: tcd_pkg::BIAS_W];
                n_results++;
                n_up_seen   += seen.up_active;
                n_down_seen += seen.down_active;
                if (seen.bias_out != 0)
                    n_bias_seen++;
                if (results_due.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, got tdata %h",
                             $time, m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (seen.climbing !== want.climbing)
                        report_mismatch("climbing", want.climbing, seen.climbing);
                    if (seen.up_active !== want.up_active)
                        report_mismatch("up_active", want.up_active, seen.up_active);
                    if (seen.down_active !== want.down_active)
                        report_mismatch("down_active", want.down_active, seen.down_active);
                    if (seen.bias_out !== want.bias_out)
                        report_mismatch("bias_out", want.bias_out, seen.bias_out);
                end
            end
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int tmo;
        int alpha;
        int ue;
        int de;
        cfg_m.hold_timeout_ms    = tcd_pkg::HOLD_TIMEOUT_RST;
        cfg_m.bias_alpha         = tcd_pkg::BIAS_ALPHA_RST;
        cfg_m.up_enter_level     = '0;
        cfg_m.up_release_level   = '0;
        cfg_m.down_enter_level   = '0;
        cfg_m.down_release_level = '0;
        up_on         = 1'b0;
        down_on       = 1'b0;
        up_since      = '0;
        down_since    = '0;
        bias_q20      = '0;
        stamp_ms      = '0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            if (i == SPLIT_ROW)
            begin
                drain();
                // alpha above one, zero hold time, narrow hysteresis band
                load_settings(0, 131071, -4096, -2048, 4096, 2048);
            end
            push_item(WALK_ROWS[i].it, WALK_ROWS[i].typed, WALK_ROWS[i].want);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            ue = $urandom_range(4096);
            ue = -ue;
            de = $urandom_range(4096);
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    load_settings(0, Q_ONE, ue, ue + $urandom_range(4096),
                                  de, de - $urandom_range(4096));
                end
                1:
                begin
                    // register extremes: flags set at once and only a long hold frees them
                    src_idle_pct   = 45;
                    sink_stall_pct = 0;
                    load_settings(65535, 0, 32767, -32768, -32768, 32767);
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 45;
                    stamp_ms       = 32'hffff_f000;   // timestamps wrap in this phase
                    tmo            = $urandom_range(1500);
                    load_settings(tmo, 131071, ue, ue + $urandom_range(4096),
                                  de, de - $urandom_range(4096));
                end
                default:
                begin
                    src_idle_pct   = 29;
                    sink_stall_pct = 29;
                    tmo            = $urandom_range(2000);
                    alpha          = $urandom_range(Q_ONE);
                    load_settings(tmo, alpha, ue, ue + $urandom_range(4096),
                                  de, de - $urandom_range(4096));
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
                push_item(next_reading(), 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d items (%0d clears) and checked %0d results after %0d register writes.",
                 n_items, n_clears, n_results, n_cfg);
        $display("Results with climb-up set: %0d, climb-down set: %0d, nonzero bias: %0d.",
                 n_up_seen, n_down_seen, n_bias_seen);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
